### rtl/multi_qubit_gate_state_update_macros.svh
// assertion macros for the multi-qubit gate state update block
`ifndef MULTI_QUBIT_GATE_STATE_UPDATE_MACROS_SVH
`define MULTI_QUBIT_GATE_STATE_UPDATE_MACROS_SVH
`ifndef ASSERT_OFF
`define MQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define MQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/mqgsu_pkg.sv
// shared types and constants of the multi-qubit gate state update block
package mqgsu_pkg;

    localparam int MAX_STATE_QUBITS = 10;
    localparam int AMP_WIDTH        = 32;
    localparam int FRAC_BITS        = AMP_WIDTH - 2;
    localparam int STORE_DEPTH      = 1 << MAX_STATE_QUBITS;
    localparam int GATE_DEPTH       = 64;
    localparam int ADDR_W           = MAX_STATE_QUBITS;
    localparam int GADDR_W          = 6;
    localparam int ACC_W            = AMP_WIDTH + 8;

    typedef enum logic [1:0] {
        CMD_LOAD_GATE = 2'd0,
        CMD_WRITE_AMP = 2'd1,
        CMD_APPLY     = 2'd2,
        CMD_READ      = 2'd3
    } command_t;

    localparam logic [2:0] REG_GATE_QUBITS  = 3'd0;
    localparam logic [2:0] REG_QUBIT_FIRST  = 3'd1;
    localparam logic [2:0] REG_QUBIT_SECOND = 3'd2;
    localparam logic [2:0] REG_QUBIT_THIRD  = 3'd3;
    localparam logic [2:0] REG_STATE_QUBITS = 3'd4;

    // product to take: which gate part times which amplitude part
    typedef enum logic [1:0] {
        MUL_RE_RE = 2'd0,
        MUL_IM_IM = 2'd1,
        MUL_RE_IM = 2'd2,
        MUL_IM_RE = 2'd3
    } mul_op_t;

    typedef struct packed {
        logic                amp_we;
        logic                amp_wr_acc;
        logic                amp_re;
        logic [ADDR_W-1:0]   amp_addr;
        logic                gate_we;
        logic                gate_re;
        logic [GADDR_W-1:0]  gate_addr;
        logic                v_we;
        logic [2:0]          v_slot;
        logic [2:0]          mul_col;
        logic                mul_en;
        mul_op_t             mul_op;
        logic                acc_clr;
        logic                res_load;
        logic                res_is_read;
        logic                res_status;
        logic [ADDR_W-1:0]   res_index;
    } dp_cmd_t;

endpackage

### rtl/multi_qubit_gate_state_update.sv
// top level of the multi-qubit gate state update block
// Gate loads and amplitude writes are written at the accepting edge; a read registers the
// amplitude in amp_rd_reg and then in the result registers, which raise done. An apply walks
// every base index of the vector in use, skipping the bases that have a target qubit bit set,
// and for each group of 2^g amplitudes (g = gate_qubits) loads the group into the slot
// registers, then reads each gate entry and forms its four real products on a single shared
// 32x32 multiplier. A bad qubit configuration answers through ST_RESP with status set.
// busy stays high until the result; done is a one-cycle strobe that is not held off.
module multi_qubit_gate_state_update (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            command,
    input  logic [mqgsu_pkg::ADDR_W-1:0]          index,
    input  logic signed [mqgsu_pkg::AMP_WIDTH-1:0] real_part,
    input  logic signed [mqgsu_pkg::AMP_WIDTH-1:0] imag_part,
    input  logic                                  cfg_we,
    input  logic [2:0]                            cfg_index,
    input  logic [3:0]                            cfg_data,
    output logic                                  done,
    output logic                                  status,
    output logic [mqgsu_pkg::ADDR_W-1:0]          amp_index,
    output logic signed [mqgsu_pkg::AMP_WIDTH-1:0] amp_real,
    output logic signed [mqgsu_pkg::AMP_WIDTH-1:0] amp_imag
);

    mqgsu_pkg::dp_cmd_t dp_cmd;

    mqgsu_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .index     (index),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cmd       (dp_cmd)
    );

    mqgsu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .real_part (real_part),
        .imag_part (imag_part),
        .done      (done),
        .status    (status),
        .amp_index (amp_index),
        .amp_real  (amp_real),
        .amp_imag  (amp_imag)
    );

endmodule

### rtl/mqgsu_datapath.sv
// amplitude and gate stores, group registers, multiply-accumulate and result registers
module mqgsu_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mqgsu_pkg::dp_cmd_t                    cmd,
    input  logic signed [mqgsu_pkg::AMP_WIDTH-1:0] real_part,
    input  logic signed [mqgsu_pkg::AMP_WIDTH-1:0] imag_part,
    output logic                                  done,
    output logic                                  status,
    output logic [mqgsu_pkg::ADDR_W-1:0]          amp_index,
    output logic signed [mqgsu_pkg::AMP_WIDTH-1:0] amp_real,
    output logic signed [mqgsu_pkg::AMP_WIDTH-1:0] amp_imag
);

    localparam int W  = mqgsu_pkg::AMP_WIDTH;
    localparam int AW = mqgsu_pkg::ACC_W;
    localparam int PW = 2 * W;
    localparam int RW = PW + 1 - mqgsu_pkg::FRAC_BITS;

    logic [PW-1:0] amp_mem  [0:mqgsu_pkg::STORE_DEPTH-1];
    logic [PW-1:0] gate_mem [0:mqgsu_pkg::GATE_DEPTH-1];
    logic [PW-1:0] amp_rd_reg;
    logic [PW-1:0] gate_rd_reg;

    logic signed [W-1:0] v_re_reg [0:7];
    logic signed [W-1:0] v_im_reg [0:7];

    logic signed [PW-1:0] prod_reg, prod_next;
    mqgsu_pkg::mul_op_t   op_reg;
    logic                 pvalid_reg;
    logic signed [AW-1:0] acc_re_reg, acc_im_reg;

    logic signed [W-1:0]  mul_a, mul_b, g_re, g_im, sat_re, sat_im;
    logic signed [PW:0]   round_sum;
    logic signed [RW-1:0] rounded;
    logic signed [AW-1:0] term;

    logic                 done_reg, status_reg;
    logic [mqgsu_pkg::ADDR_W-1:0] index_reg;
    logic signed [W-1:0]  real_reg, imag_reg;

    function automatic logic signed [W-1:0] sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi, lo;
        hi = AW'((64'sd1 <<< (W - 1)) - 64'sd1);
        lo = -hi - AW'(1);
        if (v > hi)
            sat = W'(hi);
        else if (v < lo)
            sat = W'(lo);
        else
            sat = v[W-1:0];
    endfunction

    assign g_re   = gate_rd_reg[PW-1:W];
    assign g_im   = gate_rd_reg[W-1:0];
    assign sat_re = sat(acc_re_reg);
    assign sat_im = sat(acc_im_reg);

    // stores
    always_ff @(posedge clk)
    begin
        if (cmd.amp_we)
        begin
            if (cmd.amp_wr_acc)
                amp_mem[cmd.amp_addr] <= {sat_re, sat_im};
            else
                amp_mem[cmd.amp_addr] <= {real_part, imag_part};
        end
        if (cmd.amp_re)
            amp_rd_reg <= amp_mem[cmd.amp_addr];
        if (cmd.gate_we)
            gate_mem[cmd.gate_addr] <= {real_part, imag_part};
        if (cmd.gate_re)
            gate_rd_reg <= gate_mem[cmd.gate_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.v_we)
        begin
            v_re_reg[cmd.v_slot] <= amp_rd_reg[PW-1:W];
            v_im_reg[cmd.v_slot] <= amp_rd_reg[W-1:0];
        end
    end

    always_comb
    begin
        case (cmd.mul_op)
            mqgsu_pkg::MUL_RE_RE:
            begin
                mul_a = g_re;
                mul_b = v_re_reg[cmd.mul_col];
            end
            mqgsu_pkg::MUL_IM_IM:
            begin
                mul_a = g_im;
                mul_b = v_im_reg[cmd.mul_col];
            end
            mqgsu_pkg::MUL_RE_IM:
            begin
                mul_a = g_re;
                mul_b = v_im_reg[cmd.mul_col];
            end
            default:
            begin
                mul_a = g_im;
                mul_b = v_re_reg[cmd.mul_col];
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    // round to nearest, ties up, then arithmetic shift by the fraction bits
    always_comb
    begin
        round_sum = {prod_reg[PW-1], prod_reg}
                  + ((PW + 1)'(1) <<< (mqgsu_pkg::FRAC_BITS - 1));
        rounded   = round_sum[PW:mqgsu_pkg::FRAC_BITS];
        term      = AW'(rounded);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        op_reg   <= cmd.mul_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            pvalid_reg <= cmd.mul_en;
            done_reg   <= cmd.res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (pvalid_reg)
        begin
            case (op_reg)
                mqgsu_pkg::MUL_RE_RE: acc_re_reg <= acc_re_reg + term;
                mqgsu_pkg::MUL_IM_IM: acc_re_reg <= acc_re_reg - term;
                default:              acc_im_reg <= acc_im_reg + term;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            index_reg  <= cmd.res_index;
            if (cmd.res_is_read)
            begin
                real_reg <= amp_rd_reg[PW-1:W];
                imag_reg <= amp_rd_reg[W-1:0];
            end
            else
            begin
                real_reg <= '0;
                imag_reg <= '0;
            end
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign amp_index = index_reg;
    assign amp_real  = real_reg;
    assign amp_imag  = imag_reg;

endmodule

### rtl/mqgsu_controller.sv
// configuration registers and sequencer for command handling and gate apply
`include "multi_qubit_gate_state_update_macros.svh"
module mqgsu_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [1:0]                   command,
    input  logic [mqgsu_pkg::ADDR_W-1:0] index,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [3:0]                   cfg_data,
    output logic                         busy,
    output mqgsu_pkg::dp_cmd_t           cmd
);

    localparam int AD = mqgsu_pkg::ADDR_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_RESP, ST_BASE, ST_LOAD, ST_MAC, ST_FLUSH, ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] gq_reg;
    logic [3:0] q0_reg, q1_reg, q2_reg, sq_reg;
    logic [AD:0]   base_reg, base_next;
    logic [3:0]    step_reg, step_next;
    logic [2:0]    k_reg, k_next, c_reg, c_next, sub_reg, sub_next;
    logic          status_reg, status_next;
    logic [AD-1:0] idx_reg, idx_next;

    logic          g3, bad_cfg, accept;
    logic [3:0]    n_eff, q_top;
    logic [2:0]    last;
    logic [AD:0]   len;
    logic [AD-1:0] mask;

    function automatic logic [AD-1:0] group_addr(
        input logic [AD-1:0] b, input logic [2:0] k,
        input logic [3:0] a0, input logic [3:0] a1, input logic [3:0] a2,
        input logic three);
        logic [AD-1:0] r;
        r = b;
        if (k[0]) r = r | (AD'(1) << a0);
        if (k[1]) r = r | (AD'(1) << a1);
        if (k[2] && three) r = r | (AD'(1) << a2);
        group_addr = r;
    endfunction

    assign g3     = (gq_reg == 2'd3);
    assign last   = g3 ? 3'd7 : 3'd3;
    assign n_eff  = (sq_reg > 4'(mqgsu_pkg::MAX_STATE_QUBITS))
                  ? 4'(mqgsu_pkg::MAX_STATE_QUBITS) : sq_reg;
    assign q_top  = g3 ? q2_reg : q1_reg;
    assign len    = (AD + 1)'(1) << n_eff;
    assign mask   = (AD'(1) << q0_reg) | (AD'(1) << q1_reg)
                  | (g3 ? (AD'(1) << q2_reg) : AD'(0));
    assign bad_cfg = (gq_reg != 2'd2 && gq_reg != 2'd3) || (q1_reg <= q0_reg)
                  || (g3 && q2_reg <= q1_reg) || (q_top >= n_eff);
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gq_reg <= 2'd2;
            q0_reg <= 4'd0;
            q1_reg <= 4'd1;
            q2_reg <= 4'd2;
            sq_reg <= 4'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mqgsu_pkg::REG_GATE_QUBITS:  gq_reg <= cfg_data[1:0];
                mqgsu_pkg::REG_QUBIT_FIRST:  q0_reg <= cfg_data;
                mqgsu_pkg::REG_QUBIT_SECOND: q1_reg <= cfg_data;
                mqgsu_pkg::REG_QUBIT_THIRD:  q2_reg <= cfg_data;
                mqgsu_pkg::REG_STATE_QUBITS: sq_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        step_next   = step_reg;
        k_next      = k_reg;
        c_next      = c_reg;
        sub_next    = sub_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        cmd.mul_col = c_reg;
        cmd.mul_op  = mqgsu_pkg::MUL_RE_RE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mqgsu_pkg::command_t'(command))
                        mqgsu_pkg::CMD_LOAD_GATE:
                        begin
                            cmd.gate_we   = (index[AD-1:mqgsu_pkg::GADDR_W] == '0);
                            cmd.gate_addr = index[mqgsu_pkg::GADDR_W-1:0];
                        end
                        mqgsu_pkg::CMD_WRITE_AMP:
                        begin
                            cmd.amp_we   = 1'b1;
                            cmd.amp_addr = index;
                        end
                        mqgsu_pkg::CMD_APPLY:
                        begin
                            status_next = bad_cfg;
                            base_next   = '0;
                            state_next  = bad_cfg ? ST_RESP : ST_BASE;
                        end
                        default:
                        begin
                            cmd.amp_re   = 1'b1;
                            cmd.amp_addr = index;
                            idx_next     = index;
                            state_next   = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.res_load    = 1'b1;
                cmd.res_is_read = 1'b1;
                cmd.res_index   = idx_reg;
                state_next      = ST_IDLE;
            end
            ST_RESP:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = status_reg;
                state_next     = ST_IDLE;
            end
            ST_BASE:
            begin
                if (base_reg == len)
                begin
                    state_next = ST_RESP;
                end
                else if ((base_reg[AD-1:0] & mask) != '0)
                begin
                    base_next = base_reg + 1'b1;
                end
                else
                begin
                    step_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // read data is registered in amp_rd_reg before its capture into the slot registers
                if (step_reg <= 4'(last))
                begin
                    cmd.amp_re   = 1'b1;
                    cmd.amp_addr = group_addr(base_reg[AD-1:0], step_reg[2:0],
                                              q0_reg, q1_reg, q2_reg, g3);
                end
                if (step_reg != 4'd0)
                begin
                    cmd.v_we   = 1'b1;
                    cmd.v_slot = 3'(step_reg - 4'd1);
                end
                if (step_reg == 4'(last) + 4'd1)
                begin
                    k_next     = '0;
                    c_next     = '0;
                    sub_next   = '0;
                    state_next = ST_MAC;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_MAC:
            begin
                if (sub_reg == 3'd0)
                begin
                    cmd.acc_clr   = (c_reg == 3'd0);
                    cmd.gate_re   = 1'b1;
                    cmd.gate_addr = g3 ? {k_reg, c_reg} : {2'b00, k_reg[1:0], c_reg[1:0]};
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    cmd.mul_op = mqgsu_pkg::mul_op_t'(2'(sub_reg - 3'd1));
                end
                if (sub_reg == 3'd4)
                begin
                    sub_next = '0;
                    if (c_reg == last)
                        state_next = ST_FLUSH;
                    else
                        c_next = c_reg + 3'd1;
                end
                else
                begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.amp_we     = 1'b1;
                cmd.amp_wr_acc = 1'b1;
                cmd.amp_addr   = group_addr(base_reg[AD-1:0], k_reg,
                                            q0_reg, q1_reg, q2_reg, g3);
                if (k_reg == last)
                begin
                    base_next  = base_reg + 1'b1;
                    state_next = ST_BASE;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    c_next     = '0;
                    sub_next   = '0;
                    state_next = ST_MAC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            base_reg   <= '0;
            step_reg   <= '0;
            k_reg      <= '0;
            c_reg      <= '0;
            sub_reg    <= '0;
            status_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            step_reg   <= step_next;
            k_reg      <= k_next;
            c_reg      <= c_next;
            sub_reg    <= sub_next;
            status_reg <= status_next;
            idx_reg    <= idx_next;
        end
    end

    `MQ_ASSERT_NEXT(a_result_cmd_busy, clk, rst_n, accept && (command == mqgsu_pkg::CMD_APPLY || command == mqgsu_pkg::CMD_READ), busy)
    `MQ_ASSERT_IMPLY(a_acc_write_only_in_write, clk, rst_n, cmd.amp_we && busy, state_reg == ST_WRITE && cmd.amp_wr_acc)
    `MQ_ASSERT_IMPLY(a_row_in_range, clk, rst_n, state_reg == ST_MAC || state_reg == ST_WRITE, k_reg <= last && c_reg <= last)
    `MQ_ASSERT_NEXT(a_result_single, clk, rst_n, cmd.res_load, !cmd.res_load && state_reg == ST_IDLE)

endmodule
